@@ rtl/core/two_level_weighted_cell_sampler_macros.svh @@
// assertion macros shared by the sampler rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TWO_LEVEL_WEIGHTED_CELL_SAMPLER_MACROS_SVH
`define TWO_LEVEL_WEIGHTED_CELL_SAMPLER_MACROS_SVH

// same-cycle implication
`define TLWCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlwcs check failed");

// next-cycle implication
`define TLWCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlwcs check failed");

`endif

@@ rtl/core/tlwcs_pkg.sv @@
// shared types, sizes, opcodes and helpers for the weighted cell sampler
// no dependencies; imported by the top level and tlwcs_alu
package tlwcs_pkg;

   localparam int BOARD_SIZE    = 11;
   localparam int WEIGHT_BITS   = 16;
   localparam int ROW_SUM_BITS  = 20;
   localparam int TOTAL_BITS    = 24;
   localparam int COORD_BITS    = 4;
   localparam int FIELD_W_BITS  = 16;
   localparam int RAND_BITS     = 31;
   localparam int CELL_COUNT    = BOARD_SIZE * BOARD_SIZE;
   localparam int CELL_IDX_BITS = $clog2(CELL_COUNT);
   localparam int ROW_IDX_BITS  = $clog2(BOARD_SIZE);
   localparam int PROD_BITS     = RAND_BITS + TOTAL_BITS;
   localparam int STEP_BITS     = 3;

   localparam logic [COORD_BITS:0] BOARD_LIM = (COORD_BITS + 1)'(BOARD_SIZE);
   localparam logic [COORD_BITS:0] NBR_ONE   = (COORD_BITS + 1)'(1);

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_CHANGE = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   // order of the read-modify-writes of a change
   localparam logic [STEP_BITS-1:0] STEP_UP_RIGHT  = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_RIGHT     = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_DOWN      = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_DOWN_LEFT = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_LEFT      = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_UP        = 3'd5;
   localparam logic [STEP_BITS-1:0] STEP_CENTER    = 3'd6;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [COORD_BITS-1:0]   cell_row;
      logic [COORD_BITS-1:0]   cell_col;
      logic [FIELD_W_BITS-1:0] load_weight;
      logic [FIELD_W_BITS-1:0] w_up_right;
      logic [FIELD_W_BITS-1:0] w_right;
      logic [FIELD_W_BITS-1:0] w_down;
      logic [FIELD_W_BITS-1:0] w_down_left;
      logic [FIELD_W_BITS-1:0] w_left;
      logic [FIELD_W_BITS-1:0] w_up;
      logic [RAND_BITS-1:0]    random_word;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] picked_row;
      logic [COORD_BITS-1:0] picked_col;
      logic                  hit;
   } rsp_type;

   // shared unit computes a + b - c; neg is the borrow when b is zero
   typedef struct packed {
      logic [TOTAL_BITS-1:0] a;
      logic [TOTAL_BITS-1:0] b;
      logic [TOTAL_BITS-1:0] c;
   } alu_req_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] res;
      logic                  neg;
   } alu_rsp_type;

   function automatic logic [CELL_IDX_BITS-1:0] cell_index(
      input logic [COORD_BITS:0] r,
      input logic [COORD_BITS:0] c
   );
      return CELL_IDX_BITS'(r) * CELL_IDX_BITS'(BOARD_SIZE) + CELL_IDX_BITS'(c);
   endfunction

endpackage

@@ rtl/core/two_level_weighted_cell_sampler.sv @@
// top level of the two-level weighted cell sampler: sequencer, sums, valid bits
// depends on tlwcs_pkg, tlwcs_ram, tlwcs_alu and the assertion macro header
//
//   channel   | ports                       | handshake
//   ----------+-----------------------------+-----------------------------------
//   request   | start, busy, req_item       | taken when start high, busy low
//   response  | rsp_strobe, rsp_item        | one cycle per sample, no backpressure
//
// a load updates its one cell, a change its seven cells; each in-board cell passes S_RD, S_ROWUPD, S_TOTUPD
// a sample passes S_MUL, then S_ROW over the rows walked and S_CELL over the cells walked
// one shared add/compare unit is stepped per row sum, per cell and per sum update
// reset clears weights through valid bits, row sums and the total at once
// busy stays high until the transaction is done, ignored ones leave it low; no stalls
`include "two_level_weighted_cell_sampler_macros.svh"

module two_level_weighted_cell_sampler import tlwcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MUL    = 7'b0000010,
      S_ROW    = 7'b0000100,
      S_CELL   = 7'b0001000,
      S_RD     = 7'b0010000,
      S_ROWUPD = 7'b0100000,
      S_TOTUPD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // captured transaction
   req_type req_ff, req_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   // sample walk
   logic [TOTAL_BITS-1:0]    draw_ff, draw_in;
   logic [ROW_IDX_BITS-1:0]  row_ff, row_in;
   logic [ROW_IDX_BITS-1:0]  col_ff, col_in;
   logic [CELL_IDX_BITS-1:0] cell_idx_ff, cell_idx_in;

   // read-modify-write
   logic [ROW_IDX_BITS-1:0]  tgt_row_ff, tgt_row_in;
   logic [CELL_IDX_BITS-1:0] tgt_idx_ff, tgt_idx_in;
   logic [WEIGHT_BITS-1:0]   new_w_ff, new_w_in;
   logic [WEIGHT_BITS-1:0]   old_w_ff, old_w_in;

   // architectural sums and valid bits
   logic [ROW_SUM_BITS-1:0] row_sums_ff [BOARD_SIZE];
   logic [TOTAL_BITS-1:0]   total_ff, total_in;
   logic [CELL_COUNT-1:0]   valid_ff;
   logic                    valid_rd_ff;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_item_ff, rsp_item_in;

   // ram port
   logic                     ram_wr_en;
   logic [CELL_IDX_BITS-1:0] ram_rd_addr;
   logic [WEIGHT_BITS-1:0]   ram_rd_data;
   logic [WEIGHT_BITS-1:0]   cell_w;

   // shared unit
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   // row sum port, single read index
   logic [ROW_IDX_BITS-1:0] row_sel;
   logic [ROW_SUM_BITS-1:0] row_sum_rd;
   logic                    row_wr_en;

   // neighbour target
   logic [COORD_BITS:0]    base_r, base_c, tgt_r, tgt_c;
   logic [WEIGHT_BITS-1:0] tgt_w;
   logic                   tgt_on, last_step;
   logic [CELL_IDX_BITS-1:0] tgt_idx;

   logic [PROD_BITS-1:0] prod;
   logic                 hit_on_board;
   logic                 miss_zero;
   logic                 sample_take;
   logic                 in_update;

   tlwcs_ram #(
      .DATA_BITS (WEIGHT_BITS),
      .DEPTH     (CELL_COUNT)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tgt_idx_ff),
      .wr_data (new_w_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tlwcs_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // never-written cells read as zero
   assign cell_w = valid_rd_ff ? ram_rd_data : '0;

   assign row_sel    = (state_ff == S_ROW) ? row_ff : tgt_row_ff;
   assign row_sum_rd = row_sums_ff[row_sel];

   // draw in weight units: (random * total) >> 31
   assign prod = PROD_BITS'(req_ff.random_word) * PROD_BITS'(total_ff);

   // pick the cell of the current step; off-board coordinates land at BOARD_LIM or above
   always_comb begin
      base_r = {1'b0, req_ff.cell_row};
      base_c = {1'b0, req_ff.cell_col};
      tgt_r  = base_r;
      tgt_c  = base_c;
      tgt_w  = '0;
      if (req_ff.opcode == OP_LOAD) begin
         tgt_w = WEIGHT_BITS'(req_ff.load_weight);
      end else begin
         case (step_ff)
            STEP_UP_RIGHT: begin
               tgt_r = base_r - NBR_ONE;
               tgt_c = base_c + NBR_ONE;
               tgt_w = WEIGHT_BITS'(req_ff.w_up_right);
            end
            STEP_RIGHT: begin
               tgt_c = base_c + NBR_ONE;
               tgt_w = WEIGHT_BITS'(req_ff.w_right);
            end
            STEP_DOWN: begin
               tgt_r = base_r + NBR_ONE;
               tgt_w = WEIGHT_BITS'(req_ff.w_down);
            end
            STEP_DOWN_LEFT: begin
               tgt_r = base_r + NBR_ONE;
               tgt_c = base_c - NBR_ONE;
               tgt_w = WEIGHT_BITS'(req_ff.w_down_left);
            end
            STEP_LEFT: begin
               tgt_c = base_c - NBR_ONE;
               tgt_w = WEIGHT_BITS'(req_ff.w_left);
            end
            STEP_UP: begin
               tgt_r = base_r - NBR_ONE;
               tgt_w = WEIGHT_BITS'(req_ff.w_up);
            end
            default: begin
               // center cell is cleared
               tgt_w = '0;
            end
         endcase
      end
   end

   assign tgt_on    = (tgt_r < BOARD_LIM) && (tgt_c < BOARD_LIM);
   assign tgt_idx   = cell_index(tgt_r, tgt_c);
   assign last_step = (req_ff.opcode == OP_LOAD) || (step_ff == STEP_CENTER);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      step_in       = step_ff;
      draw_in       = draw_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cell_idx_in   = cell_idx_ff;
      tgt_row_in    = tgt_row_ff;
      tgt_idx_in    = tgt_idx_ff;
      new_w_in      = new_w_ff;
      old_w_in      = old_w_ff;
      total_in      = total_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      ram_wr_en     = 1'b0;
      row_wr_en     = 1'b0;
      ram_rd_addr   = cell_idx_ff;
      alu_req.a     = draw_ff;
      alu_req.b     = '0;
      alu_req.c     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in  = req_item;
               step_in = '0;
               case (req_item.opcode)
                  OP_LOAD, OP_CHANGE: begin
                     // whole transaction dropped when the named cell is off board
                     if (({1'b0, req_item.cell_row} < BOARD_LIM) &&
                         ({1'b0, req_item.cell_col} < BOARD_LIM)) begin
                        state_in = S_RD;
                     end
                  end
                  OP_SAMPLE: begin
                     state_in = S_MUL;
                  end
                  default: begin
                     // unknown opcode, nothing to do
                  end
               endcase
            end
         end

         S_MUL: begin
            draw_in  = prod[RAND_BITS +: TOTAL_BITS];
            row_in   = '0;
            state_in = S_ROW;
         end

         S_ROW: begin
            alu_req.a = draw_ff;
            alu_req.c = TOTAL_BITS'(row_sum_rd);
            if (alu_rsp.neg) begin
               // row found, prefetch its first cell
               ram_rd_addr = cell_index((COORD_BITS + 1)'(row_ff), '0);
               cell_idx_in = ram_rd_addr;
               col_in      = '0;
               state_in    = S_CELL;
            end else begin
               draw_in = alu_rsp.res;
               if (row_ff == ROW_IDX_BITS'(BOARD_SIZE - 1)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end

         S_CELL: begin
            alu_req.a = draw_ff;
            alu_req.c = TOTAL_BITS'(cell_w);
            if (alu_rsp.neg) begin
               rsp_strobe_in          = 1'b1;
               rsp_item_in.picked_row = COORD_BITS'(row_ff);
               rsp_item_in.picked_col = COORD_BITS'(col_ff);
               rsp_item_in.hit        = 1'b1;
               state_in               = S_IDLE;
            end else begin
               draw_in = alu_rsp.res;
               if (col_ff == ROW_IDX_BITS'(BOARD_SIZE - 1)) begin
                  // walked past the row end, miss
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  // next cell read overlaps this compare
                  ram_rd_addr = cell_idx_ff + 1'b1;
                  cell_idx_in = cell_idx_ff + 1'b1;
                  col_in      = col_ff + 1'b1;
               end
            end
         end

         S_RD: begin
            if (tgt_on) begin
               ram_rd_addr = tgt_idx;
               tgt_idx_in  = tgt_idx;
               tgt_row_in  = tgt_r[ROW_IDX_BITS-1:0];
               new_w_in    = tgt_w;
               state_in    = S_ROWUPD;
            end else if (last_step) begin
               state_in = S_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         S_ROWUPD: begin
            alu_req.a = TOTAL_BITS'(row_sum_rd);
            alu_req.b = TOTAL_BITS'(new_w_ff);
            alu_req.c = TOTAL_BITS'(cell_w);
            row_wr_en = 1'b1;
            ram_wr_en = 1'b1;
            old_w_in  = cell_w;
            state_in  = S_TOTUPD;
         end

         S_TOTUPD: begin
            alu_req.a = total_ff;
            alu_req.b = TOTAL_BITS'(new_w_ff);
            alu_req.c = TOTAL_BITS'(old_w_ff);
            total_in  = alu_rsp.res;
            if (last_step) begin
               state_in = S_IDLE;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         total_ff      <= '0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         total_ff      <= total_in;
         if (ram_wr_en) begin
            valid_ff[tgt_idx_ff] <= 1'b1;
         end
      end
   end

   // row sums wrap modulo their width
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BOARD_SIZE; i++) begin
            row_sums_ff[i] <= '0;
         end
      end else if (row_wr_en) begin
         row_sums_ff[tgt_row_ff] <= alu_rsp.res[ROW_SUM_BITS-1:0];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      step_ff     <= step_in;
      draw_ff     <= draw_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cell_idx_ff <= cell_idx_in;
      tgt_row_ff  <= tgt_row_in;
      tgt_idx_ff  <= tgt_idx_in;
      new_w_ff    <= new_w_in;
      old_w_ff    <= old_w_in;
      valid_rd_ff <= valid_ff[ram_rd_addr];
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   assign hit_on_board = ({1'b0, rsp_item_ff.picked_row} < BOARD_LIM) &&
                         ({1'b0, rsp_item_ff.picked_col} < BOARD_LIM);
   assign miss_zero    = (rsp_item_ff.picked_row == '0) && (rsp_item_ff.picked_col == '0);
   assign sample_take  = start && !busy && (req_item.opcode == OP_SAMPLE);
   assign in_update    = (state_ff == S_RD) || (state_ff == S_ROWUPD) ||
                         (state_ff == S_TOTUPD);

   `TLWCS_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `TLWCS_ASSERT_IMP(a_hit_on_board, clock, reset, rsp_strobe_ff && rsp_item_ff.hit, hit_on_board)
   `TLWCS_ASSERT_IMP(a_miss_zero, clock, reset, rsp_strobe_ff && !rsp_item_ff.hit, miss_zero)
   `TLWCS_ASSERT_NXT(a_sample_starts, clock, reset, sample_take, state_ff == S_MUL)
   `TLWCS_ASSERT_IMP(a_no_strobe_in_update, clock, reset, in_update, !rsp_strobe_ff)

endmodule

@@ rtl/core/tlwcs_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; holds the cell weights of the sampler
module tlwcs_ram #(
   parameter int DATA_BITS = 16,
   parameter int DEPTH     = 121
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tlwcs_alu.sv @@
// shared add/subtract/compare unit of the sampler sequencer
// depends on tlwcs_pkg
module tlwcs_alu import tlwcs_pkg::*; (
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [TOTAL_BITS:0] sum;

   assign sum = {1'b0, alu_req.a} + {1'b0, alu_req.b} - {1'b0, alu_req.c};

   assign alu_rsp.res = sum[TOTAL_BITS-1:0];
   assign alu_rsp.neg = sum[TOTAL_BITS];

endmodule
